// File: src/mastep_pkg.sv
// Shared types and constants of the multi-axis step generator.
// Used by the top level; no dependencies.
`default_nettype none
package mastep_pkg;

	localparam int AXES_DEF = 4;
	localparam int CART_AXES_DEF = 3;

	localparam int CFG_W = 88;   // cap, accel, steps_needed
	localparam int DYN_W = 168;  // peak, position, phase tick, steps_taken

	typedef enum logic [2:0] {
		FN_LOAD   = 3'd0,
		FN_LINEAR = 3'd1,
		FN_HOME   = 3'd2,
		FN_TICK   = 3'd3,
		FN_LIMIT  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_LIN  = 2'd1,
		M_HOME = 2'd2
	} mode_t;

endpackage
`default_nettype wire

// File: src/multi_axis_accel_step_generator.sv
// Top level of the multi-axis step generator: command decode, per-axis sequencer,
// shared 32x32 multiplier. Depends on mastep_pkg and mastep_ram.
//
// channel | dir | tdata                                   | tuser | tlast
// s_axis  | in  | axis,step_count,accel,speed_limit,allow  | func  | -
// m_axis  | out | step_mask,busy_res,moving_mask          | -     | finished
//
// Starting a linear or homing run adds a sweep over all AXES entries of the state
// memory. A tick visits the axes in turn: an axis in the run goes through read,
// seven multiplier steps and write back; any other axis is only passed over.
// Reset clears control state; the motion state memory is cleared by the start
// sweeps, and a configuration entry is read only after a load of its axis.
// A tick result waits in the output register; new beats are taken meanwhile.
`default_nettype none
module multi_axis_accel_step_generator #(
	parameter int AXES = mastep_pkg::AXES_DEF,
	parameter int CART_AXES = mastep_pkg::CART_AXES_DEF,
	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] axis, [25:2] step_count, [57:26] accel, [89:58] speed_limit, [90] allowed
	input  wire logic [95:0] s_tdata,
	// [2:0] func
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [3:0] step_mask, [4] busy_res, [8:5] moving_mask
	output logic [15:0]      m_tdata,
	// finished
	output logic             m_tlast
);
	typedef enum logic [2:0] {S_IDLE, S_CLR, S_RD, S_MUL, S_WB, S_DONE} state_t;

	state_t state_q;
	mastep_pkg::mode_t mode_q;
	logic [23:0] tick_q;
	logic [AXES-1:0] moving_q, pin_q, decel_q, neednz_q, cart_m;
	logic [AW-1:0] ax_q;
	logic [2:0] st_q;
	logic clr_home_q, capped_q;
	logic [23:0] u_q;
	logic [47:0] sq_q;
	logic [79:0] q_q, p2_q;
	logic [55:0] pk_q;
	logic [63:0] mres_q;

	logic [mastep_pkg::CFG_W-1:0] cfg_rd, cfg_wd;
	logic [mastep_pkg::DYN_W-1:0] dyn_rd, dyn_wd;
	logic cfg_we, dyn_we, rd_en;
	logic [AW-1:0] cfg_wa;

	logic acc_in, in_range, is_last, is_cart, part, lin, lindec, homcap;
	mastep_pkg::func_t fn;
	logic [1:0] in_axis;
	logic [23:0] need, taken, ptick, taken_n, u_c;
	logic [31:0] acc_a, cap, mul_a, mul_b;
	logic [63:0] pos;
	logic [55:0] peak;
	logic [81:0] h82, up82, sraw;
	logic [63:0] s_pos;
	logic differs, capped_c;
	logic [AXES-1:0] mask_c;
	logic [AXES+3:0] pad_pin, pad_mask;

	assign s_tready = (state_q == S_IDLE);
	assign acc_in = s_tvalid && s_tready;
	assign fn = mastep_pkg::func_t'(s_tuser);
	assign in_axis = s_tdata[1:0];
	assign in_range = 32'(in_axis) < AXES;
	assign is_last = ax_q == AW'(AXES - 1);
	assign is_cart = 32'(ax_q) < CART_AXES;
	assign lin = (mode_q == mastep_pkg::M_LIN);

	assign {need, acc_a, cap} = {cfg_rd[23:0], cfg_rd[55:24], cfg_rd[87:56]};
	assign taken = dyn_rd[23:0];
	assign ptick = dyn_rd[47:24];
	assign pos = dyn_rd[111:48];
	assign peak = dyn_rd[167:112];

	assign lindec = lin && decel_q[ax_q];
	assign homcap = !lin && capped_q;
	assign u_c = (tick_q >= ptick) ? tick_q - ptick : 24'd0;
	assign capped_c = {8'd0, peak} > {32'd0, cap};
	assign taken_n = taken + 24'd1;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			cart_m[i] = i < CART_AXES;
		end
		part = lin ? (neednz_q[ax_q] && moving_q[ax_q]) : (is_cart && moving_q[ax_q]);
		mask_c = lin ? (neednz_q & moving_q) : (cart_m & moving_q);
		pad_pin = {4'd0, pin_q};
		pad_mask = {4'd0, mask_c};
	end

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (st_q)
			3'd0: begin
				if (lin) begin
					mul_a = {8'd0, decel_q[ax_q] ? u_c : tick_q};
				end else begin
					mul_a = {8'd0, capped_c ? ptick : tick_q};
				end
				mul_b = mul_a;
			end
			3'd1: begin
				mul_a = lindec ? peak[31:0] : (homcap ? cap : 32'd0);
				mul_b = {8'd0, u_q};
			end
			3'd2: begin
				mul_a = lindec ? {8'd0, peak[55:32]} : 32'd0;
				mul_b = {8'd0, u_q};
			end
			3'd3: begin
				mul_a = acc_a;
				mul_b = {8'd0, tick_q};
			end
			3'd4: begin
				mul_a = acc_a;
				mul_b = sq_q[31:0];
			end
			3'd5: begin
				mul_a = acc_a;
				mul_b = {16'd0, sq_q[47:32]};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_comb begin
		h82 = {3'd0, p2_q[79:1]};
		up82 = {2'd0, q_q} + {18'd0, pos};
		if (lindec) begin
			sraw = (up82 < h82) ? 82'd0 : up82 - h82;
		end else begin
			sraw = h82 + {2'd0, q_q};
		end
		s_pos = (|sraw[81:64]) ? {64{1'b1}} : sraw[63:0];
		differs = s_pos[55:32] != taken;
	end

	always_comb begin
		dyn_we = 1'b0;
		dyn_wd = dyn_rd;
		cfg_we = 1'b0;
		cfg_wa = ax_q;
		cfg_wd = {cap, acc_a, 24'd0};
		rd_en = (state_q == S_RD) && part;
		if (state_q == S_CLR) begin
			dyn_we = !clr_home_q || is_cart;
			dyn_wd = '0;
		end else if (state_q == S_WB) begin
			dyn_we = 1'b1;
			if (lin) begin
				if (!pin_q[ax_q] && differs) begin
					dyn_wd[23:0] = taken_n;
					if (taken_n == {1'b0, need[23:1]}) begin
						dyn_wd[47:24] = tick_q;
						dyn_wd[111:48] = s_pos;
						dyn_wd[167:112] = pk_q;
					end
					cfg_we = taken_n == need;
				end
			end else begin
				if (differs) begin
					dyn_wd[23:0] = taken_n;
				end
				if (!capped_q) begin
					dyn_wd[47:24] = tick_q;
					dyn_wd[167:112] = pk_q;
				end
			end
		end else if (acc_in && fn == mastep_pkg::FN_LOAD && mode_q == mastep_pkg::M_IDLE
				&& in_range) begin
			cfg_we = 1'b1;
			cfg_wa = AW'(in_axis);
			cfg_wd = {s_tdata[89:58], s_tdata[57:26], s_tdata[25:2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= mastep_pkg::M_IDLE;
			tick_q <= '0;
			moving_q <= '0;
			pin_q <= '0;
			decel_q <= '0;
			neednz_q <= '0;
			ax_q <= '0;
			st_q <= '0;
			clr_home_q <= 1'b0;
			capped_q <= 1'b0;
			u_q <= '0;
			sq_q <= '0;
			q_q <= '0;
			p2_q <= '0;
			pk_q <= '0;
			mres_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tlast <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						case (fn)
							mastep_pkg::FN_LIMIT: begin
								if (in_range && 32'(in_axis) < CART_AXES) begin
									moving_q[AW'(in_axis)] <= 1'b0;
								end
							end
							mastep_pkg::FN_TICK: begin
								if (mode_q != mastep_pkg::M_IDLE) begin
									if (tick_q != 24'hFFFFFF) begin
										tick_q <= tick_q + 24'd1;
									end
									ax_q <= '0;
									state_q <= S_RD;
								end
							end
							mastep_pkg::FN_LOAD: begin
								if (mode_q == mastep_pkg::M_IDLE && in_range) begin
									moving_q[AW'(in_axis)] <= s_tdata[90];
									neednz_q[AW'(in_axis)] <= s_tdata[25:2] != 24'd0;
								end
							end
							mastep_pkg::FN_LINEAR: begin
								if (mode_q == mastep_pkg::M_IDLE) begin
									mode_q <= mastep_pkg::M_LIN;
									tick_q <= '0;
									for (int i = 0; i < AXES; i++) begin
										moving_q[i] <= neednz_q[i]
											&& (i >= CART_AXES || moving_q[i]);
									end
									pin_q <= '0;
									decel_q <= '0;
									ax_q <= '0;
									clr_home_q <= 1'b0;
									state_q <= S_CLR;
								end
							end
							mastep_pkg::FN_HOME: begin
								if (mode_q == mastep_pkg::M_IDLE) begin
									mode_q <= mastep_pkg::M_HOME;
									tick_q <= '0;
									ax_q <= '0;
									clr_home_q <= 1'b1;
									state_q <= S_CLR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLR: begin
					if (is_last) begin
						state_q <= S_IDLE;
					end else begin
						ax_q <= ax_q + AW'(1);
					end
				end
				S_RD: begin
					if (part) begin
						st_q <= '0;
						state_q <= S_MUL;
					end else if (is_last) begin
						state_q <= S_DONE;
					end else begin
						ax_q <= ax_q + AW'(1);
					end
				end
				S_MUL: begin
					mres_q <= 64'(mul_a) * 64'(mul_b);
					st_q <= st_q + 3'd1;
					case (st_q)
						3'd0: begin
							u_q <= u_c;
							capped_q <= capped_c;
						end
						3'd1: sq_q <= mres_q[47:0];
						3'd2: q_q <= {16'd0, mres_q};
						3'd3: q_q <= q_q + {mres_q[47:0], 32'd0};
						3'd4: pk_q <= mres_q[55:0];
						3'd5: p2_q <= {16'd0, mres_q};
						default: begin
							p2_q <= p2_q + {mres_q[47:0], 32'd0};
							state_q <= S_WB;
						end
					endcase
				end
				S_WB: begin
					if (lin) begin
						if (pin_q[ax_q]) begin
							pin_q[ax_q] <= 1'b0;
						end else if (differs) begin
							pin_q[ax_q] <= 1'b1;
							if (taken_n == {1'b0, need[23:1]}) begin
								decel_q[ax_q] <= 1'b1;
							end
							if (taken_n == need) begin
								neednz_q[ax_q] <= 1'b0;
							end
						end
					end else begin
						pin_q[ax_q] <= differs;
					end
					if (is_last) begin
						state_q <= S_DONE;
					end else begin
						ax_q <= ax_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						if (mask_c == '0) begin
							mode_q <= mastep_pkg::M_IDLE;
						end
						m_tvalid <= 1'b1;
						m_tlast <= mask_c == '0;
						m_tdata <= {7'd0, pad_mask[3:0], mask_c != '0, pad_pin[3:0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	mastep_ram #(.WIDTH(mastep_pkg::CFG_W), .DEPTH(AXES)) u_cfg_ram (
		.clk(clk), .we(cfg_we), .waddr(cfg_wa), .wdata(cfg_wd),
		.re(rd_en), .raddr(ax_q), .rdata(cfg_rd)
	);

	mastep_ram #(.WIDTH(mastep_pkg::DYN_W), .DEPTH(AXES)) u_dyn_ram (
		.clk(clk), .we(dyn_we), .waddr(ax_q), .wdata(dyn_wd),
		.re(rd_en), .raddr(ax_q), .rdata(dyn_rd)
	);

`ifndef SYNTH
	a_ax_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> 32'(ax_q) < AXES)
		else $error("axis index out of range");
	a_fin_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[4])
		else $error("finished beat reports busy");
	a_mul_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> mode_q != mastep_pkg::M_IDLE)
		else $error("axis update with no run active");
`endif
endmodule
`default_nettype wire

// File: src/mastep_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mastep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: dv/tb_multi_axis_accel_step_generator.sv
// Testbench of the multi-axis step generator: random and directed command beats,
// a built-in motion predictor and an in-order check of every tick result.
// Depends on mastep_pkg and multi_axis_accel_step_generator.
`default_nettype none
module tb_multi_axis_accel_step_generator;

	localparam int AXES = mastep_pkg::AXES_DEF;
	localparam int CART = mastep_pkg::CART_AXES_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		mastep_pkg::func_t func;
		logic [1:0]  axis;
		logic [23:0] steps;
		logic [31:0] accel;
		logic [31:0] cap;
		logic        allowed;
		bit          hold;
		bit          has_res;
		logic [3:0]  step_mask;
		logic        busy;
		logic        finished;
		logic [3:0]  moving;
	} cmd_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [15:0]  m_tdata;
	logic         m_tlast;

	cmd_t pending[$];
	cmd_t pulse_q[$];
	cmd_t cur;
	int   errors = 0;
	int   snd_wait = 0;
	int   rcv_wait = 0;
	int   quiet = 0;
	int   cyc = 0;
	bit   no_idle = 0;

	// motion state
	logic [23:0] tick_n;
	mastep_pkg::mode_t run_st;
	logic [23:0] need_steps[AXES];
	logic [23:0] done_steps[AXES];
	logic [31:0] accel_r[AXES];
	logic [31:0] cap_r[AXES];
	logic        decel[AXES];
	logic        pin[AXES];
	logic        moving[AXES];
	logic [23:0] peak_tick[AXES];
	logic [63:0] peak_pos[AXES];
	logic [55:0] peak_vel[AXES];

	multi_axis_accel_step_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] sat64(logic [127:0] v);
		return (|v[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
	endfunction

	function automatic void step_if_behind(int i, logic [63:0] s);
		if (s[55:32] != done_steps[i]) begin
			pin[i] = 1;
			done_steps[i] = done_steps[i] + 24'd1;
			if (run_st == mastep_pkg::M_LIN) begin
				if (done_steps[i] == (need_steps[i] >> 1)) begin
					decel[i] = 1;
					peak_pos[i] = s;
					peak_tick[i] = tick_n;
					peak_vel[i] = 56'(64'(accel_r[i]) * 64'(tick_n));
				end
				if (done_steps[i] == need_steps[i])
					need_steps[i] = 0;
			end
		end
	endfunction

	function automatic void linear_axis(int i);
		logic [127:0] a, t, u, up, dn;
		logic [63:0]  s;
		a = 128'(accel_r[i]);
		t = 128'(tick_n);
		if (need_steps[i] == 0 || !moving[i])
			return;
		if (!decel[i]) begin
			s = sat64((a * t * t) >> 1);
		end else begin
			u = (tick_n >= peak_tick[i]) ? 128'(tick_n - peak_tick[i]) : 128'd0;
			up = 128'(peak_pos[i]) + 128'(peak_vel[i]) * u;
			dn = (a * u * u) >> 1;
			s = (up < dn) ? 64'd0 : sat64(up - dn);
		end
		if (pin[i])
			pin[i] = 0;
		else
			step_if_behind(i, s);
	endfunction

	function automatic void home_axis(int i);
		logic [127:0] a, t, tp, u;
		logic [63:0]  s;
		a = 128'(accel_r[i]);
		t = 128'(tick_n);
		if (!moving[i])
			return;
		if (64'(peak_vel[i]) <= 64'(cap_r[i])) begin
			peak_vel[i] = 56'(a * t);
			s = sat64((a * t * t) >> 1);
			peak_tick[i] = tick_n;
		end else begin
			tp = 128'(peak_tick[i]);
			u = (tick_n >= peak_tick[i]) ? 128'(tick_n - peak_tick[i]) : 128'd0;
			s = sat64(((a * tp * tp) >> 1) + 128'(cap_r[i]) * u);
		end
		if (pin[i])
			pin[i] = 0;
		step_if_behind(i, s);
	endfunction

	function automatic void apply_command(ref cmd_t c);
		bit done;
		c.has_res = 0;
		case (c.func)
			mastep_pkg::FN_LIMIT: begin
				if (c.axis < CART)
					moving[c.axis] = 0;
			end
			mastep_pkg::FN_TICK: begin
				if (run_st != mastep_pkg::M_IDLE) begin
					if (tick_n != 24'hFFFFFF)
						tick_n = tick_n + 24'd1;
					done = 1;
					c.step_mask = '0;
					c.moving = '0;
					for (int i = 0; i < AXES; i++) begin
						if (run_st == mastep_pkg::M_LIN) begin
							linear_axis(i);
							if (need_steps[i] != 0 && moving[i]) begin
								done = 0;
								c.moving[i] = 1;
							end
						end else if (i < CART) begin
							home_axis(i);
							if (moving[i]) begin
								done = 0;
								c.moving[i] = 1;
							end
						end
						if (pin[i])
							c.step_mask[i] = 1;
					end
					if (done)
						run_st = mastep_pkg::M_IDLE;
					c.busy = (run_st != mastep_pkg::M_IDLE);
					c.finished = done;
					c.has_res = 1;
				end
			end
			mastep_pkg::FN_LOAD: begin
				if (run_st == mastep_pkg::M_IDLE) begin
					need_steps[c.axis] = c.steps;
					accel_r[c.axis] = c.accel;
					cap_r[c.axis] = c.cap;
					moving[c.axis] = c.allowed;
				end
			end
			mastep_pkg::FN_LINEAR: begin
				if (run_st == mastep_pkg::M_IDLE) begin
					run_st = mastep_pkg::M_LIN;
					tick_n = 0;
					for (int i = 0; i < AXES; i++) begin
						moving[i] = (need_steps[i] != 0) && (i >= CART || moving[i]);
						done_steps[i] = 0;
						decel[i] = 0;
						pin[i] = 0;
						peak_tick[i] = 0;
						peak_pos[i] = 0;
						peak_vel[i] = 0;
					end
				end
			end
			mastep_pkg::FN_HOME: begin
				if (run_st == mastep_pkg::M_IDLE) begin
					run_st = mastep_pkg::M_HOME;
					tick_n = 0;
					for (int i = 0; i < CART; i++) begin
						peak_vel[i] = 0;
						done_steps[i] = 0;
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send(mastep_pkg::func_t f, int ax, logic [23:0] st, logic [31:0] ac,
			logic [31:0] cp, bit al, bit hold = 0);
		cmd_t c;
		c.func = f;
		c.axis = 2'(ax);
		c.steps = st;
		c.accel = ac;
		c.cap = cp;
		c.allowed = al;
		c.hold = hold;
		apply_command(c);
		pending.push_back(c);
	endtask

	task automatic tick();
		send(mastep_pkg::FN_TICK, $urandom_range(0, 3), 24'($urandom), $urandom, $urandom,
			1'($urandom));
	endtask

	task automatic limit(int ax);
		send(mastep_pkg::FN_LIMIT, ax, 24'($urandom), $urandom, $urandom, 1'($urandom));
	endtask

	task automatic noise();
		case ($urandom_range(0, 2))
			0: send(mastep_pkg::func_t'(3'($urandom_range(5, 7))), $urandom_range(0, 3),
				24'($urandom), $urandom, $urandom, 1'($urandom));
			1: send(mastep_pkg::FN_LOAD, $urandom_range(0, 3), 24'($urandom), $urandom,
				$urandom, 1'($urandom));
			default: send(mastep_pkg::func_t'(3'($urandom_range(1, 2))), 0, 24'($urandom),
				$urandom, $urandom, 1'($urandom));
		endcase
	endtask

	task automatic finish_run();
		int n;
		n = 0;
		while (run_st != mastep_pkg::M_IDLE && n < 20) begin
			tick();
			n++;
		end
		for (int i = 0; i < CART; i++)
			limit(i);
		while (run_st != mastep_pkg::M_IDLE)
			tick();
	endtask

	task automatic load_random(int ax);
		logic [23:0] st;
		logic [31:0] ac;
		if (ax == CART) begin
			st = 24'($urandom_range(0, 60));
			ac = $urandom_range(32'h0400_0000, 32'hFFFF_FFFF);
		end else begin
			st = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
			case ($urandom_range(0, 9))
				0: ac = $urandom;
				1: ac = 0;
				default: ac = $urandom_range(32'h0400_0000, 32'h8000_0000);
			endcase
		end
		send(mastep_pkg::FN_LOAD, ax, st, ac, $urandom, 1'($urandom_range(0, 3) != 0));
	endtask

	initial begin
		int items, n;
		tick_n = 0;
		run_st = mastep_pkg::M_IDLE;
		for (int i = 0; i < AXES; i++) begin
			need_steps[i] = 0; done_steps[i] = 0; accel_r[i] = 0; cap_r[i] = 0;
			decel[i] = 0; pin[i] = 0; moving[i] = 0;
			peak_tick[i] = 0; peak_pos[i] = 0; peak_vel[i] = 0;
		end

		// directed: ignored items, extremes, a linear move and homing runs
		send(mastep_pkg::func_t'(3'd5), 0, '1, '1, '1, 1);
		send(mastep_pkg::func_t'(3'd6), 1, 0, 0, 0, 0);
		send(mastep_pkg::func_t'(3'd7), 2, '1, 0, '1, 1);
		tick();
		limit(3);
		send(mastep_pkg::FN_LOAD, 0, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send(mastep_pkg::FN_LOAD, 1, 0, 0, 0, 0);
		send(mastep_pkg::FN_LOAD, 2, 24'd20, 32'h4000_0000, 32'h0, 0);
		send(mastep_pkg::FN_LOAD, 3, 24'd6, 32'h8000_0000, 32'h5555_AAAA, 0);
		send(mastep_pkg::FN_LINEAR, 0, 0, 0, 0, 0);
		send(mastep_pkg::FN_LOAD, 1, 24'd9, 32'h1, 32'h1, 1);
		for (int k = 0; k < 6; k++)
			tick();
		limit(0);
		limit(3);
		finish_run();
		send(mastep_pkg::FN_LOAD, 1, 24'd40, 32'h4000_0000, 32'h8000_0000, 1, 1);
		send(mastep_pkg::FN_LOAD, 2, 24'd0, 32'h0, 32'h0, 1);
		send(mastep_pkg::FN_HOME, 0, 0, 0, 0, 0);
		for (int k = 0; k < 8; k++)
			tick();
		finish_run();
		send(mastep_pkg::FN_HOME, 0, 0, 0, 0, 0);
		tick();

		items = pending.size();
		while (items < 1000) begin
			for (int ax = 0; ax < AXES; ax++)
				if ($urandom_range(0, 4) != 0)
					load_random(ax);
			send($urandom_range(0, 3) == 0 ? mastep_pkg::FN_HOME : mastep_pkg::FN_LINEAR,
				0, 0, 0, 0, 0, $urandom_range(0, 9) == 0);
			n = $urandom_range(5, 120);
			for (int k = 0; k < n && run_st != mastep_pkg::M_IDLE; k++) begin
				if ($urandom_range(0, 9) == 0)
					noise();
				if ($urandom_range(0, 39) == 0)
					limit($urandom_range(0, 3));
				tick();
			end
			finish_run();
			if ($urandom_range(0, 5) == 0) begin
				tick();
				noise();
				limit($urandom_range(0, 3));
			end
			items = pending.size();
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;
		do @(posedge clk);
		while (pending.size() != 0 || s_tvalid || pulse_q.size() != 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb_multi_axis_accel_step_generator: done, clean");
		else
			$display("tb_multi_axis_accel_step_generator: done, errors");
		$finish;
	end

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 19);
	endfunction

	// idle pattern and watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 400 == 0)
			no_idle <= ($urandom_range(0, 3) == 0);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb_multi_axis_accel_step_generator: done, errors");
			$finish;
		end
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			snd_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid && cur.has_res)
				pulse_q.push_back(cur);
			if (snd_wait > 0) begin
				snd_wait <= snd_wait - 1;
				s_tvalid <= 0;
			end else if (pending.size() != 0 && !(pending[0].hold && pulse_q.size() != 0)) begin
				cur = pending.pop_front();
				s_tdata <= {5'b0, cur.allowed, cur.cap, cur.accel, cur.steps, cur.axis};
				s_tuser <= cur.func;
				s_tvalid <= 1;
				snd_wait <= draw_wait();
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		cmd_t e;
		int w;
		if (!arst_n) begin
			m_tready <= 0;
			rcv_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			if (pulse_q.size() == 0) begin
				$error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
				errors++;
			end else begin
				e = pulse_q.pop_front();
				if (m_tdata[3:0] !== e.step_mask) begin
					$error("step_mask: expected %h, actual %h", e.step_mask, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[4] !== e.busy) begin
					$error("busy_res: expected %b, actual %b", e.busy, m_tdata[4]);
					errors++;
				end
				if (m_tlast !== e.finished) begin
					$error("finished: expected %b, actual %b", e.finished, m_tlast);
					errors++;
				end
				if (m_tdata[8:5] !== e.moving) begin
					$error("moving_mask: expected %h, actual %h", e.moving, m_tdata[8:5]);
					errors++;
				end
			end
			w = draw_wait();
			rcv_wait <= w;
			m_tready <= (w == 0);
		end else if (rcv_wait > 0) begin
			rcv_wait <= rcv_wait - 1;
			m_tready <= (rcv_wait == 1);
		end else begin
			m_tready <= 1;
		end
	end

endmodule
`default_nettype wire
